[rtl/core/json_string_unescaper_utf8_core_assert.svh]
// Assertion macros used by the checker file (jsu_checker.sv).
`ifndef JSON_STRING_UNESCAPER_UTF8_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPER_UTF8_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jsu check failed");

// Consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsu check failed");

`endif

[rtl/core/jsu_pkg.sv]
package jsu_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } jsu_out_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_NOQUOTE = 3'd2;
  localparam logic [2:0] ST_BADESC  = 3'd3;
  localparam logic [2:0] ST_ENDED   = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STR    = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_HIWAIT = 3'd4,
    MODE_HIESC  = 3'd5,
    MODE_HIHEX  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_CP   = 2'd2,
    KIND_STAT = 2'd3
  } kind_e;

  // One queue entry: an optional pending high surrogate, then at most one main result.
  typedef struct packed {
    logic        pend;
    logic [9:0]  ph;
    kind_e       kind;
    logic [20:0] val;
  } jsu_desc_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE      = 21'h10000;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_dec(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.val   = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.valid = 1'b1;
      r.val   = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.valid = 1'b1;
    unique case (c)
      CH_QUOTE:  r.val = CH_QUOTE;
      CH_BSLASH: r.val = CH_BSLASH;
      CH_SLASH:  r.val = CH_SLASH;
      8'h62:     r.val = 8'h08;
      8'h66:     r.val = 8'h0C;
      8'h6E:     r.val = CH_LF;
      8'h72:     r.val = CH_CR;
      8'h74:     r.val = CH_TAB;
      default: begin
        r.valid = 1'b0;
        r.val   = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.b[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      r.len  = 3'd3;
      r.b[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      r.b[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.b[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      r.b[1] = UTF8_CONT | {2'b00, cp[17:12]};
      r.b[2] = UTF8_CONT | {2'b00, cp[11:6]};
      r.b[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[rtl/core/jsu_front.sv]
module jsu_front import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  jsu_in_t   item_i,
  output logic      push_o,
  output jsu_desc_t desc_o
);

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  ph_q, ph_d;

  logic [7:0]  c;
  hex_t        hx;
  esc_t        esc;
  logic [15:0] acc_new;
  logic        done;
  logic        is_high;
  logic        is_low;
  logic        is_ws;
  logic        hi_mode;

  assign c       = item_i.in_byte;
  assign hx      = hex_dec(c);
  assign esc     = esc_map(c);
  assign acc_new = {acc_q[11:0], hx.val};
  assign done    = (cnt_q == 2'd3);
  assign is_high = (acc_new[15:10] == SURR_HIGH_BASE[15:10]);
  assign is_low  = (acc_new[15:10] == SURR_LOW_BASE[15:10]);
  assign is_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  assign hi_mode = (mode_q == MODE_HIWAIT) || (mode_q == MODE_HIESC) || (mode_q == MODE_HIHEX);

  always_comb begin
    mode_d = mode_q;
    if (accept_i) begin
      if (item_i.op == OP_END) begin
        mode_d = MODE_IDLE;
      end else begin
        unique case (mode_q)
          MODE_IDLE: begin
            if (c == CH_QUOTE) mode_d = MODE_STR;
          end
          MODE_STR: begin
            if (c == CH_QUOTE) mode_d = MODE_IDLE;
            else if (c == CH_BSLASH) mode_d = MODE_ESC;
          end
          MODE_ESC: begin
            if (esc.valid) mode_d = MODE_STR;
            else if (c == CH_U) mode_d = MODE_HEX;
            else mode_d = MODE_IDLE;
          end
          MODE_HEX: begin
            if (!hx.valid) mode_d = MODE_IDLE;
            else if (done) mode_d = is_high ? MODE_HIWAIT : MODE_STR;
          end
          MODE_HIWAIT: begin
            if (c == CH_BSLASH) mode_d = MODE_HIESC;
            else if (c == CH_QUOTE) mode_d = MODE_IDLE;
            else mode_d = MODE_STR;
          end
          MODE_HIESC: begin
            if (c == CH_U) mode_d = MODE_HIHEX;
            else if (esc.valid) mode_d = MODE_STR;
            else mode_d = MODE_IDLE;
          end
          MODE_HIHEX: begin
            if (!hx.valid) mode_d = MODE_IDLE;
            else if (done) mode_d = (is_low || !is_high) ? MODE_STR : MODE_HIWAIT;
          end
          default: mode_d = MODE_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    desc_o      = '0;
    desc_o.ph   = ph_q;
    desc_o.kind = KIND_NONE;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    ph_d        = ph_q;
    if (accept_i) begin
      cnt_d = 2'd0;
      acc_d = 16'd0;
      if (item_i.op == OP_END) begin
        desc_o.pend = hi_mode;
        desc_o.kind = KIND_STAT;
        desc_o.val  = {18'd0, ST_ENDED};
      end else begin
        unique case (mode_q) inside
          MODE_IDLE: begin
            if (c != CH_QUOTE && !is_ws) begin
              desc_o.kind = KIND_STAT;
              desc_o.val  = {18'd0, ST_NOQUOTE};
            end
          end
          MODE_STR, MODE_HIWAIT: begin
            // a lone high surrogate flushes before the byte is handled as usual
            desc_o.pend = (mode_q == MODE_HIWAIT) && (c != CH_BSLASH);
            if (c == CH_QUOTE) begin
              desc_o.kind = KIND_STAT;
              desc_o.val  = {18'd0, ST_CLOSED};
            end else if (c != CH_BSLASH) begin
              desc_o.kind = KIND_BYTE;
              desc_o.val  = {13'd0, c};
            end
          end
          MODE_ESC, MODE_HIESC: begin
            desc_o.pend = (mode_q == MODE_HIESC) && (c != CH_U);
            if (esc.valid) begin
              desc_o.kind = KIND_BYTE;
              desc_o.val  = {13'd0, esc.val};
            end else if (c != CH_U) begin
              desc_o.kind = KIND_STAT;
              desc_o.val  = {18'd0, ST_BADESC};
            end
          end
          MODE_HEX, MODE_HIHEX: begin
            if (!hx.valid) begin
              desc_o.pend = (mode_q == MODE_HIHEX);
              desc_o.kind = KIND_STAT;
              desc_o.val  = {18'd0, ST_BADESC};
            end else if (!done) begin
              cnt_d = cnt_q + 2'd1;
              acc_d = acc_new;
            end else if ((mode_q == MODE_HIHEX) && is_low) begin
              desc_o.kind = KIND_CP;
              desc_o.val  = SUPP_BASE + {1'b0, ph_q, acc_new[9:0]};
            end else begin
              // four valid digits that do not pair up start a fresh code point
              desc_o.pend = (mode_q == MODE_HIHEX);
              if (is_high) begin
                ph_d = acc_new[9:0];
              end else begin
                desc_o.kind = KIND_CP;
                desc_o.val  = {5'd0, acc_new};
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign push_o = accept_i && (desc_o.pend || (desc_o.kind != KIND_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= 2'd0;
      acc_q  <= 16'd0;
      ph_q   <= 10'd0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      ph_q   <= ph_d;
    end
  end

endmodule

[rtl/core/jsu_queue.sv]
module jsu_queue import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  jsu_desc_t desc_i,
  output logic      full_o,
  output logic      head_valid_o,
  output jsu_desc_t head_o,
  input  logic      pop_i
);

  jsu_desc_t          entry_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/jsu_back.sv]
module jsu_back import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  jsu_desc_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output jsu_out_t  out_data_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  jsu_out_t   data_q, data_d;

  utf8_t      pend_u;
  utf8_t      main_u;
  logic [2:0] main_len;
  logic [2:0] total;
  logic [2:0] j;
  logic       load;
  jsu_out_t   cur;

  assign pend_u = utf8_enc({5'd0, SURR_HIGH_BASE[15:10], head_i.ph});
  assign main_u = utf8_enc(head_i.val);

  always_comb begin
    unique case (head_i.kind)
      KIND_NONE: main_len = 3'd0;
      KIND_CP:   main_len = main_u.len;
      default:   main_len = 3'd1;
    endcase
    total = (head_i.pend ? 3'd3 : 3'd0) + main_len;
    j     = idx_q - (head_i.pend ? 3'd3 : 3'd0);

    cur = '0;
    if (head_i.pend && (idx_q < 3'd3)) begin
      cur.out_byte = pend_u.b[idx_q[1:0]];
    end else begin
      unique case (head_i.kind)
        KIND_BYTE: cur.out_byte = head_i.val[7:0];
        KIND_CP:   cur.out_byte = main_u.b[j[1:0]];
        KIND_STAT: cur.status   = head_i.val[2:0];
        default: ;
      endcase
    end
    cur.last = (idx_q == total - 3'd1);
  end

  // load a new item whenever the output register is empty or being taken
  assign load  = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load && cur.last;

  always_comb begin
    idx_d   = idx_q;
    data_d  = data_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      data_d  = cur;
      idx_d   = cur.last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/json_string_unescaper_utf8_core.sv]
// An item's first result goes through a queue entry and then the output register.
// Throughput: one item per cycle while the output is not stalled and each item gives
// at most one result; the 4-entry queue between the parser and the UTF-8 expander
// absorbs the bursts of items that give several results before input stalls.
// Reset: parser idle awaiting an opening quote, queue empty, output invalid.
module json_string_unescaper_utf8_core import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  jsu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output jsu_out_t out_data_o
);

  logic      accept;
  logic      push;
  logic      full;
  logic      head_valid;
  logic      pop;
  jsu_desc_t desc;
  jsu_desc_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push),
    .desc_o   (desc)
  );

  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[rtl/core/jsu_checker.sv]
`include "json_string_unescaper_utf8_core_assert.svh"

module jsu_checker import jsu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input jsu_out_t out_data_o
);

  logic is_status;

  assign is_status = out_valid_o && (out_data_o.status != ST_BYTE);

  // a stalled item holds
  `JSU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // status results carry no byte
  `JSU_ASSERT_NOW(a_status_zero_byte, is_status, out_data_o.out_byte == 8'h00)

  // a status always ends the burst of its item
  `JSU_ASSERT_NOW(a_status_last, is_status, out_data_o.last)

  // status stays within the defined codes
  `JSU_ASSERT_NOW(a_status_range, out_valid_o, out_data_o.status <= ST_ENDED)

  // a full queue implies the output register already holds an item
  `JSU_ASSERT_NOW(a_stall_has_output, in_stall_o, out_valid_o)

endmodule

bind json_string_unescaper_utf8_core jsu_checker u_jsu_checker (.*);

[tb/sv/json_string_unescaper_utf8_core_tb.sv]
`timescale 1ns / 100ps

module json_string_unescaper_utf8_core_tb;
  import jsu_pkg::*;

  localparam logic [15:0] HIGH_TOP    = 16'hDBFF;
  localparam logic [15:0] LOW_TOP     = 16'hDFFF;
  localparam logic [7:0]  CH_BSPACE   = 8'h08;
  localparam logic [7:0]  CH_FFEED    = 8'h0C;
  localparam int unsigned DIRECTED_N  = 24;
  localparam int unsigned RANDOM_N    = 436;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  jsu_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  jsu_out_t out_data_o;

  json_string_unescaper_utf8_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Decoder state mirror and queue of UTF-8 results still due from the block.
  class unescape_scoreboard;
    mode_e       mode;
    logic [1:0]  digits_seen;
    logic [15:0] hex_acc;
    logic [9:0]  high_part;
    jsu_out_t    decoded_due[$];
    jsu_out_t    burst[$];
    int unsigned sources;
    int unsigned decoded;
    int unsigned mismatches;
    int unsigned pairs;
    int unsigned error_codes;

    function new();
      to_idle();
      sources     = 0;
      decoded     = 0;
      mismatches  = 0;
      pairs       = 0;
      error_codes = 0;
    endfunction

    function void to_idle();
      mode        = MODE_IDLE;
      digits_seen = '0;
      hex_acc     = '0;
      high_part   = '0;
    endfunction

    function void emit(logic [7:0] b, logic [2:0] st);
      jsu_out_t r;
      r.out_byte = b;
      r.status   = st;
      r.last     = 1'b0;
      if (st != ST_BYTE && st != ST_CLOSED) error_codes++;
      if (burst.size() < 6) burst.insert(burst.size(), r);
    endfunction

    function void emit_cp(logic [20:0] cp);
      if (cp < 21'h80) begin
        emit(cp[7:0], ST_BYTE);
      end else if (cp < 21'h800) begin
        emit(UTF8_LEAD2 | {3'b000, cp[10:6]}, ST_BYTE);
        emit(UTF8_CONT | {2'b00, cp[5:0]}, ST_BYTE);
      end else if (cp < SUPP_BASE) begin
        emit(UTF8_LEAD3 | {4'b0000, cp[15:12]}, ST_BYTE);
        emit(UTF8_CONT | {2'b00, cp[11:6]}, ST_BYTE);
        emit(UTF8_CONT | {2'b00, cp[5:0]}, ST_BYTE);
      end else begin
        emit(UTF8_LEAD4 | {5'b00000, cp[20:18]}, ST_BYTE);
        emit(UTF8_CONT | {2'b00, cp[17:12]}, ST_BYTE);
        emit(UTF8_CONT | {2'b00, cp[11:6]}, ST_BYTE);
        emit(UTF8_CONT | {2'b00, cp[5:0]}, ST_BYTE);
      end
    endfunction

    function void flush_high();
      emit_cp(21'(SURR_HIGH_BASE) + 21'(high_part));
      high_part = '0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void on_string(logic [7:0] c);
      if (c == CH_QUOTE) begin
        emit(8'h00, ST_CLOSED);
        to_idle();
      end else if (c == CH_BSLASH) begin
        mode = MODE_ESC;
      end else begin
        emit(c, ST_BYTE);
      end
    endfunction

    function void on_escape(logic [7:0] c);
      logic [7:0] v;
      bit         known;
      known = 1'b1;
      v     = c;
      case (c)
        CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
        "b": v = CH_BSPACE;
        "f": v = CH_FFEED;
        "n": v = CH_LF;
        "r": v = CH_CR;
        "t": v = CH_TAB;
        CH_U: begin
          mode        = MODE_HEX;
          digits_seen = '0;
          hex_acc     = '0;
          return;
        end
        default: known = 1'b0;
      endcase
      if (!known) begin
        emit(8'h00, ST_BADESC);
        to_idle();
      end else begin
        emit(v, ST_BYTE);
        mode = MODE_STR;
      end
    endfunction

    function void on_hex(logic [7:0] c, bit low_wanted);
      int          d;
      logic [15:0] cp;
      d = hex_digit(c);
      if (d < 0) begin
        if (low_wanted) flush_high();
        emit(8'h00, ST_BADESC);
        to_idle();
        return;
      end
      hex_acc = {hex_acc[11:0], 4'(d)};
      if (digits_seen != 2'd3) begin
        digits_seen++;
        return;
      end
      digits_seen = '0;
      cp          = hex_acc;
      hex_acc     = '0;
      if (low_wanted) begin
        if (cp >= SURR_LOW_BASE && cp <= LOW_TOP) begin
          emit_cp(SUPP_BASE + 21'({high_part, 10'b0}) + 21'(cp - SURR_LOW_BASE));
          high_part = '0;
          mode      = MODE_STR;
          pairs++;
          return;
        end
        flush_high();
      end
      if (cp >= SURR_HIGH_BASE && cp <= HIGH_TOP) begin
        high_part = cp[9:0];
        mode      = MODE_HIWAIT;
      end else begin
        emit_cp(21'(cp));
        mode = MODE_STR;
      end
    endfunction

    function void take_source(jsu_in_t it);
      logic [7:0] c;
      jsu_out_t   tail;
      c = it.in_byte;
      burst.delete();
      sources++;
      if (it.op == OP_END) begin
        if (mode == MODE_HIWAIT || mode == MODE_HIESC || mode == MODE_HIHEX) flush_high();
        emit(8'h00, ST_ENDED);
        to_idle();
      end else begin
        case (mode)
          MODE_IDLE: begin
            if (c == CH_QUOTE) mode = MODE_STR;
            else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF))
              emit(8'h00, ST_NOQUOTE);
          end
          MODE_STR: on_string(c);
          MODE_ESC: on_escape(c);
          MODE_HEX: on_hex(c, 1'b0);
          MODE_HIWAIT: begin
            if (c == CH_BSLASH) begin
              mode = MODE_HIESC;
            end else begin
              flush_high();
              mode = MODE_STR;
              on_string(c);
            end
          end
          MODE_HIESC: begin
            if (c == CH_U) begin
              mode        = MODE_HIHEX;
              digits_seen = '0;
              hex_acc     = '0;
            end else begin
              flush_high();
              on_escape(c);
            end
          end
          MODE_HIHEX: on_hex(c, 1'b1);
          default: to_idle();
        endcase
      end
      if (burst.size() > 0) begin
        tail      = burst.pop_back();
        tail.last = 1'b1;
        burst.insert(burst.size(), tail);
      end
      foreach (burst[i]) decoded_due.insert(decoded_due.size(), burst[i]);
    endfunction

    function void check_decoded(jsu_out_t got);
      jsu_out_t want;
      decoded++;
      if (decoded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte=%h status=%0d last=%0b",
                   got.out_byte, got.status, got.last);
        return;
      end
      want = decoded_due.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected byte=%h status=%0d last=%0b, %s",
                   decoded, want.out_byte, want.status, want.last,
                   $sformatf("got byte=%h status=%0d last=%0b",
                             got.out_byte, got.status, got.last));
      end
    endfunction
  endclass

  unescape_scoreboard sb;
  jsu_in_t            source_q[$];
  int unsigned        cycle_count;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("json_string_unescaper_utf8_core verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null && out_valid_o && !out_stall_i) sb.check_decoded(out_data_o);
  end

  task automatic push_byte(logic [7:0] b);
    jsu_in_t it;
    it.op      = OP_BYTE;
    it.in_byte = b;
    source_q.insert(source_q.size(), it);
  endtask

  task automatic push_end();
    jsu_in_t it;
    it.op      = OP_END;
    it.in_byte = 8'($urandom_range(255));
    source_q.insert(source_q.size(), it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return "0" + {4'h0, n};
    if ($urandom_range(1) == 1) base = "a";
    else base = "A";
    return base + {4'h0, n} - 8'd10;
  endfunction

  task automatic push_u(logic [15:0] cp);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    for (int i = 3; i >= 0; i--) push_byte(hex_char(cp[i*4 +: 4]));
  endtask

  function automatic logic [15:0] random_bmp();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h007F;
          3: return 16'h0080;
          4: return 16'h07FF;
          default: return 16'h0800;
        endcase
      end
      1: return 16'($urandom_range(16'h007F));
      2: return 16'($urandom_range(16'h07FF, 16'h0080));
      3: return 16'($urandom_range(16'hD7FF, 16'h0800));
      4: return 16'($urandom_range(16'hFFFF, 16'hE000));
      default: return 16'($urandom_range(LOW_TOP, SURR_LOW_BASE));
    endcase
  endfunction

  function automatic logic [15:0] random_high();
    return 16'($urandom_range(HIGH_TOP, SURR_HIGH_BASE));
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  // One literal: whitespace, then a stray byte, an end, or a quote, tokens and maybe a close.
  task automatic gen_literal();
    logic [7:0] b;
    int         n_tok;
    int         k;
    repeat ($urandom_range(2)) begin
      case ($urandom_range(3))
        0: push_byte(CH_SPACE);
        1: push_byte(CH_TAB);
        2: push_byte(CH_CR);
        default: push_byte(CH_LF);
      endcase
    end
    if ($urandom_range(99) < 8) begin
      push_byte(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(99) < 4) begin
      push_end();
      return;
    end
    push_byte(CH_QUOTE);
    n_tok = $urandom_range(8, 1);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: begin
          do b = 8'($urandom_range(255));
          while (b == CH_QUOTE || b == CH_BSLASH);
          push_byte(b);
        end
        7, 8, 9: begin
          push_byte(CH_BSLASH);
          push_byte(simple_escape());
        end
        10, 11, 12: push_u(random_bmp());
        13, 14: begin
          push_u(random_high());
          push_u(16'($urandom_range(LOW_TOP, SURR_LOW_BASE)));
        end
        15: push_u(random_high());
        16: begin
          push_u(random_high());
          if ($urandom_range(1) == 1) push_u(random_high());
          else push_u(random_bmp());
        end
        17: begin
          push_u(random_high());
          push_byte(CH_BSLASH);
          push_byte(simple_escape());
        end
        18: begin
          if ($urandom_range(1) == 1) push_u(random_high());
          push_byte(CH_BSLASH);
          do b = 8'($urandom_range(255));
          while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_U ||
                 b == "b" || b == "f" || b == "n" || b == "r" || b == "t");
          push_byte(b);
          return;
        end
        default: begin
          if ($urandom_range(1) == 1) push_u(random_high());
          push_byte(CH_BSLASH);
          push_byte(CH_U);
          k = $urandom_range(3);
          repeat (k) push_byte(hex_char(4'($urandom_range(15))));
          do b = 8'($urandom_range(255));
          while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
          push_byte(b);
          return;
        end
      endcase
    end
    if ($urandom_range(99) < 86) push_byte(CH_QUOTE);
    else if ($urandom_range(1) == 1) push_end();
  endtask

  task automatic run_receiver();
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && sb.sources >= 120) begin
        // hold off long enough for the internal queue to fill and stall the input
        hold_done = 1'b1;
        hold_left = 90;
        out_stall_i <= 1'b1;
      end else if (sb.sources >= 250 && sb.sources < 340) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 38);
      end
    end
  endtask

  task automatic drive_sources();
    bit gaps_on;
    @(negedge clk_i);
    foreach (source_q[idx]) begin
      gaps_on = !(idx >= 250 && idx < 340);
      while (gaps_on && $urandom_range(99) < 38) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= source_q[idx];
      do @(posedge clk_i);
      while (in_stall_o);
      sb.take_source(source_q[idx]);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cycle_count = 0;
    sb          = new();

    // whitespace and a stray byte while idle, then a string with extremes,
    // an escape, a joined surrogate pair, a bad escape and two text ends
    push_byte(CH_TAB);
    push_byte(8'hFF);
    push_byte(CH_QUOTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\\t");
    push_text("\\uD83D\\ude00");
    push_text("\\q");
    push_byte(CH_QUOTE);
    push_end();
    push_end();
    while (source_q.size() < DIRECTED_N + RANDOM_N) gen_literal();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      run_receiver();
    join_none
    drive_sources();

    while (sb.decoded_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Fed %0d source items (%0d directed) and checked %0d UTF-8 results.",
             sb.sources, DIRECTED_N, sb.decoded);
    $display("Joined %0d surrogate pairs, saw %0d error codes, %0d mismatches.",
             sb.pairs, sb.error_codes, sb.mismatches);
    if (sb.mismatches == 0 && sb.decoded_due.size() == 0) begin
      $display("json_string_unescaper_utf8_core verification clean");
    end else begin
      $display("json_string_unescaper_utf8_core verification failed");
    end
    $finish;
  end

endmodule
